// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands, clocked on posedge and gated by an
// active-low reset. Define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/pfla_pkg.sv =====
// ---------------------------------------------------------------------------
// pfla_pkg
// Word formats and codes of the page free-list allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfla_pkg;

  localparam int PGN_W  = 10;
  localparam int STAT_W = 2;
  localparam int TOT_W  = 11;

  // action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

  typedef struct packed {
    logic             action;
    logic [PGN_W-1:0] page_number;
  } in_word_t;

  typedef struct packed {
    logic [PGN_W-1:0]  page_number_res;
    logic [STAT_W-1:0] status;
    logic [TOT_W-1:0]  total_pages;
  } out_word_t;

endpackage

// ===== hw/rtl/pfla_stream_if.sv =====
// ---------------------------------------------------------------------------
// pfla_stream_if
// Valid/ready channel carrying one word per handshake.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfla_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== hw/rtl/pfla_link_mem.sv =====
// ---------------------------------------------------------------------------
// pfla_link_mem
// Next-free link store: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfla_link_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int LW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [LW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [LW-1:0] rdata
);

  logic [LW-1:0] mem [DEPTH];
  logic [LW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/page_free_list_allocator.sv =====
// Allocate or free: accepted in ST_IDLE, then ST_POP or ST_FREE loads the
// result register once the output slot is free. Growth (allocate on an
// empty list) first passes ST_FILL, where the fill sequencer writes one link
// per cycle, then ST_PRE re-reads the head. A new word is taken only in
// ST_IDLE, once the last result is loaded. Reset: synchronous; a fill pass
// builds the initial chain 1..INIT_PAGES-1, input not ready meanwhile.
// ---------------------------------------------------------------------------
// page_free_list_allocator
// LIFO page free list threaded through a link memory, with doubling growth.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module page_free_list_allocator #(
  parameter int MAX_PAGES  = 1024,
  parameter int INIT_PAGES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  pfla_stream_if.sink   in_if,
  pfla_stream_if.source out_if
);

  import pfla_pkg::*;

  // page index, link (index plus end flag), and page count widths
  localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int LW = AW + 1;
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int XW = (CW > PGN_W) ? CW : PGN_W;

  // end of list: all ones, msb set marks it
  localparam logic [LW-1:0] END_LINK = '1;
  localparam logic [CW-1:0] MAX_CNT  = CW'(MAX_PAGES);
  localparam logic [CW-1:0] INIT_CNT = CW'(INIT_PAGES);
  localparam logic [LW-1:0] INIT_HEAD = LW'(INIT_PAGES - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_FILL = 6'b000010,   // link chain writer, one page per cycle
    ST_PRE  = 6'b000100,   // head re-read after growth
    ST_POP  = 6'b001000,
    ST_FREE = 6'b010000,
    ST_FULL = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [LW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   fill_i_r, fill_i_nxt;
  logic [CW-1:0]   fill_hi_r, fill_hi_nxt;
  logic [LW-1:0]   prev_r, prev_nxt;
  logic            grow_r, grow_nxt;
  logic [PGN_W-1:0] pgn_r, pgn_nxt;

  logic            out_valid_r;
  out_word_t       out_word_r;
  out_word_t       ld_word;
  logic            out_load;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [LW-1:0]   mem_wdata;
  logic [LW-1:0]   mem_rdata;

  logic            in_fire;
  logic            slot_free;
  logic [CW:0]     grow_cnt;
  logic            grow_full;
  logic [CW-1:0]   fill_inc;
  logic            pgn_bad;

  // -------------------------------------------------------------------------
  // Link memory. The read port always follows the head, so the head's link
  // is ready in the cycle after any accept.
  // -------------------------------------------------------------------------
  pfla_link_mem #(
    .DEPTH (MAX_PAGES),
    .AW    (AW),
    .LW    (LW)
  ) u_link_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (head_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_fire     = in_if.valid && in_if.ready;
  assign slot_free   = !out_valid_r || out_if.ready;

  // growth check: doubled count against the page limit
  assign grow_cnt  = {count_r, 1'b0};
  assign grow_full = grow_cnt > {1'b0, MAX_CNT};

  // shared step counter of the fill sequencer
  assign fill_inc = fill_i_r + CW'(1);

  // free of header page or of a page not yet created
  assign pgn_bad = (pgn_r == '0) || (XW'(pgn_r) >= XW'(count_r));

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    fill_i_nxt  = fill_i_r;
    fill_hi_nxt = fill_hi_r;
    prev_nxt    = prev_r;
    grow_nxt    = grow_r;
    pgn_nxt     = pgn_r;
    mem_we      = 1'b0;
    mem_waddr   = fill_i_r[AW-1:0];
    mem_wdata   = prev_r;
    out_load    = 1'b0;
    ld_word.page_number_res = '0;
    ld_word.status          = STAT_OK;
    ld_word.total_pages     = TOT_W'(count_r);

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          pgn_nxt = in_if.data.page_number;
          if (in_if.data.action == ACT_FREE) begin
            state_nxt = ST_FREE;
          end else if (head_r[AW]) begin
            if (grow_full) begin
              state_nxt = ST_FULL;
            end else begin
              // chain pages count..2*count-1, each linking to the one below, page count ending the list
              fill_i_nxt  = count_r;
              fill_hi_nxt = grow_cnt[CW-1:0];
              prev_nxt    = END_LINK;
              grow_nxt    = 1'b1;
              state_nxt   = ST_FILL;
            end
          end else begin
            state_nxt = ST_POP;
          end
        end
      end

      ST_FILL: begin
        mem_we     = 1'b1;
        prev_nxt   = {1'b0, fill_i_r[AW-1:0]};
        fill_i_nxt = fill_inc;
        if (fill_inc == fill_hi_r) begin
          if (grow_r) begin
            count_nxt = fill_hi_r;
            head_nxt  = {1'b0, fill_i_r[AW-1:0]};
            state_nxt = ST_PRE;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_PRE: begin
        state_nxt = ST_POP;
      end

      ST_POP: begin
        if (slot_free) begin
          out_load = 1'b1;
          ld_word.page_number_res = PGN_W'(head_r[AW-1:0]);
          head_nxt  = mem_rdata;
          state_nxt = ST_IDLE;
        end
      end

      ST_FREE: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (pgn_bad) begin
            ld_word.status = STAT_BAD;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = AW'(pgn_r);
            mem_wdata = head_r;
            head_nxt  = {1'b0, AW'(pgn_r)};
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_FULL: begin
        if (slot_free) begin
          out_load       = 1'b1;
          ld_word.status = STAT_FULL;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // reset starts the fill pass that lays down the initial chain 1..INIT-1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_FILL;
      head_r    <= INIT_HEAD;
      count_r   <= INIT_CNT;
      fill_i_r  <= CW'(1);
      fill_hi_r <= INIT_CNT;
      prev_r    <= END_LINK;
      grow_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      fill_i_r  <= fill_i_nxt;
      fill_hi_r <= fill_hi_nxt;
      prev_r    <= prev_nxt;
      grow_r    <= grow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pgn_r <= pgn_nxt;
  end

  // -------------------------------------------------------------------------
  // Result register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r <= ld_word;
    end
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_word_r;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `ASSERT_IMPLIES(a_head_in_range, clk, rst_n, !head_r[AW], (head_r[AW-1:0] != '0) && (CW'(head_r[AW-1:0]) < count_r), "head is not a live page")
  `ASSERT_ALWAYS(a_count_bounds, clk, rst_n, (count_r <= MAX_CNT) && (count_r >= CW'(2)), "page count out of bounds")
  `ASSERT_NEXT(a_grow_starts, clk, rst_n, in_fire && (in_if.data.action == ACT_ALLOC) && head_r[AW] && !grow_full, state_r == ST_FILL, "growth did not start")
  `ASSERT_IMPLIES(a_load_busy, clk, rst_n, out_load, !in_if.ready, "result loaded while taking input")

endmodule

// ===== test/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the page free-list allocator. A prediction of the
// free list (link memory, head, page count) gives the answer word of every
// request; answers from the block are checked in order, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  import pfla_pkg::*;

  localparam int MAX_PAGES  = 1024;
  localparam int INIT_PAGES = 16;
  localparam int CLK_HALF   = 4;        // 8 ns period
  localparam int CYCLE_CAP  = 400000;   // watchdog, many times the slowest run
  localparam int REPORT_MAX = 10;

  // End of list: all ones at link width, never a real page.
  localparam logic [TOT_W-1:0] END_PG = '1;

  logic clk;
  logic rst_n;

  pfla_stream_if #(.payload_t(in_word_t))  in_if ();
  pfla_stream_if #(.payload_t(out_word_t)) out_if ();

  page_free_list_allocator #(
    .MAX_PAGES (MAX_PAGES),
    .INIT_PAGES(INIT_PAGES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .out_if(out_if)
  );

  // -------------------------------------------------------------------------
  // Predicted allocator state. Updated when a request word is queued; since
  // every queued word is taken in order and gives exactly one answer, the
  // answer queue lines up with what the block returns.
  // -------------------------------------------------------------------------
  logic [TOT_W-1:0] link_mem [0:MAX_PAGES-1];
  logic [TOT_W-1:0] head_pg;
  int               page_total;

  in_word_t         request_q[$];   // words waiting for the driver
  out_word_t        answer_q[$];    // answers still owed by the block
  logic [PGN_W-1:0] held_q[$];      // pages handed out and not yet freed

  int src_idle;                     // percent of cycles the sender holds off
  int snk_idle;                     // percent of cycles the receiver stalls
  int n_checked;
  int n_errors;
  int n_growth;
  int n_full;
  int n_bad;

  // Answer to one request; advances the predicted state.
  function automatic out_word_t allocator_answer(input in_word_t w);
    out_word_t        a;
    logic [TOT_W-1:0] prev;
    int               grown;
    int               i;
    bit               ok;
    a  = '0;
    ok = 1'b1;
    if (w.action == ACT_ALLOC) begin
      // empty list (end mark, or any head past the last page): grow first
      if (head_pg >= MAX_PAGES) begin
        grown = page_total * 2;
        if (grown > MAX_PAGES) begin
          ok       = 1'b0;
          a.status = STAT_FULL;
        end else begin
          // chain new pages so the highest one comes out first
          prev = END_PG;
          for (i = page_total; i < grown; i++) begin
            link_mem[i] = prev;
            prev        = TOT_W'(i);
          end
          page_total = grown;
          head_pg    = prev;
          n_growth++;
        end
      end
      if (ok) begin
        a.page_number_res = head_pg[PGN_W-1:0];
        head_pg = (head_pg < MAX_PAGES) ? link_mem[head_pg] : END_PG;
      end
    end else begin
      if (w.page_number == '0 || w.page_number >= page_total) begin
        a.status = STAT_BAD;
      end else begin
        // plain push; a second free of the same page is not caught
        link_mem[w.page_number] = head_pg;
        head_pg                 = TOT_W'(w.page_number);
      end
    end
    a.total_pages = TOT_W'(page_total);
    return a;
  endfunction

  // Queue one request word together with its answer.
  task automatic send_request(input logic act, input logic [PGN_W-1:0] pg);
    in_word_t  w;
    out_word_t a;
    int        k;
    w.action      = act;
    w.page_number = pg;
    a = allocator_answer(w);
    request_q.push_back(w);
    answer_q.push_back(a);
    if (a.status == STAT_FULL) n_full++;
    if (a.status == STAT_BAD) n_bad++;
    if (act == ACT_ALLOC && a.status == STAT_OK) begin
      held_q.push_back(a.page_number_res);
    end else if (act == ACT_FREE && a.status == STAT_OK) begin
      k = 0;
      while (k < held_q.size() && held_q[k] != pg) k++;
      if (k < held_q.size()) held_q.delete(k);
    end
  endtask

  // Random requests: allocates, frees of held pages, and invalid frees.
  // Frees of in-range pages come only from the held list, since a second
  // free of a page closes the list into a loop for the rest of the run.
  task automatic random_mix(input int n, input int alloc_pct, input int noise_pct);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < noise_pct) begin
        if (page_total < MAX_PAGES && $urandom_range(1) == 1)
          send_request(ACT_FREE, PGN_W'($urandom_range(MAX_PAGES - 1, page_total)));
        else
          send_request(ACT_FREE, '0);
      end else if (r < noise_pct + alloc_pct || held_q.size() == 0) begin
        send_request(ACT_ALLOC, PGN_W'($urandom_range(MAX_PAGES - 1)));
      end else begin
        send_request(ACT_FREE, held_q[$urandom_range(held_q.size() - 1)]);
      end
    end
  endtask

  // Block until the block has answered everything queued so far.
  task automatic drain;
    while (answer_q.size() != 0) @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // Clock and reset
  // -------------------------------------------------------------------------
  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // -------------------------------------------------------------------------
  // Driver: holds a word until it is taken, then may idle before the next one.
  // The block is not ready during its post-reset fill pass; the handshake
  // covers that.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (request_q.size() != 0 && $urandom_range(99) >= src_idle) begin
        in_if.valid <= 1'b1;
        in_if.data  <= request_q.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: random back-pressure, and an in-order check of every answer.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_idle);
      if (out_if.valid && out_if.ready) begin
        if (answer_q.size() == 0) begin
          n_errors++;
          if (n_errors <= REPORT_MAX)
            $display("unexpected answer word: page %0d status %0d total %0d",
                     out_if.data.page_number_res, out_if.data.status,
                     out_if.data.total_pages);
        end else begin
          e = answer_q.pop_front();
          n_checked++;
          if (out_if.data.page_number_res !== e.page_number_res ||
              out_if.data.status !== e.status ||
              out_if.data.total_pages !== e.total_pages) begin
            n_errors++;
            if (n_errors <= REPORT_MAX)
              $display("mismatch %0d: exp pg %0d st %0d tot %0d, got pg %0d st %0d tot %0d",
                       n_checked, e.page_number_res, e.status, e.total_pages,
                       out_if.data.page_number_res, out_if.data.status,
                       out_if.data.total_pages);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_CAP) @(posedge clk);
    $display("timeout after %0d cycles, %0d answers owed", CYCLE_CAP, answer_q.size());
    $display("TB_ERROR");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    logic [PGN_W-1:0] pg;
    int               i;
    n_checked = 0;
    n_errors  = 0;
    n_growth  = 0;
    n_full    = 0;
    n_bad     = 0;

    // state right after reset: page i links to i-1, pages 0 and 1 end the list
    for (i = 0; i < MAX_PAGES; i++)
      link_mem[i] = (i <= 1) ? END_PG : TOT_W'(i - 1);
    head_pg    = TOT_W'(INIT_PAGES - 1);
    page_total = INIT_PAGES;

    // Phase 1: sender idles a fifth of the time, receiver stalls often.
    src_idle = 20;
    snk_idle = 62;

    // Directed: page field ignored on allocate, at both extremes.
    send_request(ACT_ALLOC, '1);
    send_request(ACT_ALLOC, '0);
    // Invalid frees: header page, first page past the count, top of field.
    send_request(ACT_FREE, '0);
    send_request(ACT_FREE, PGN_W'(INIT_PAGES));
    send_request(ACT_FREE, '1);
    // Good free answers page 0; LIFO hands the same page straight back.
    send_request(ACT_FREE, PGN_W'(INIT_PAGES - 1));
    send_request(ACT_ALLOC, PGN_W'($urandom_range(MAX_PAGES - 1)));
    send_request(ACT_FREE, PGN_W'(INIT_PAGES - 2));
    send_request(ACT_ALLOC, '0);
    // Empty the initial list, then one more allocate forces a doubling.
    while (head_pg < MAX_PAGES)
      send_request(ACT_ALLOC, PGN_W'($urandom_range(MAX_PAGES - 1)));
    send_request(ACT_ALLOC, PGN_W'($urandom_range(MAX_PAGES - 1)));
    // Free the lowest page and the newest, highest one.
    send_request(ACT_FREE, PGN_W'(1));
    send_request(ACT_FREE, PGN_W'(page_total - 1));

    // Mostly allocates, so the count keeps doubling.
    random_mix(200, 85, 5);
    drain();

    // Phase 2: roles swapped, balanced traffic.
    src_idle = 62;
    snk_idle = 20;
    random_mix(50, 45, 10);
    drain();

    // Phase 3: no idling. Allocate until the list is empty at the top size,
    // then ask for more: no room to grow.
    src_idle = 0;
    snk_idle = 0;
    while (!(head_pg >= MAX_PAGES && page_total * 2 > MAX_PAGES))
      send_request(ACT_ALLOC, PGN_W'($urandom_range(MAX_PAGES - 1)));
    repeat (3) send_request(ACT_ALLOC, PGN_W'($urandom_range(MAX_PAGES - 1)));
    random_mix(20, 45, 10);

    // Double free last of all: it loops the list for good.
    if (held_q.size() == 0)
      send_request(ACT_ALLOC, '0);
    pg = held_q[$urandom_range(held_q.size() - 1)];
    send_request(ACT_FREE, pg);
    send_request(ACT_FREE, pg);
    repeat (4) send_request(ACT_ALLOC, PGN_W'($urandom_range(MAX_PAGES - 1)));
    drain();

    // let any stray word show up
    repeat (40) @(posedge clk);

    $display("Summary: %0d answer words checked; pages grew to %0d in %0d doublings",
             n_checked, page_total, n_growth);
    $display("Summary: %0d no-room answers, %0d invalid frees, %0d mismatches",
             n_full, n_bad, n_errors);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
